// ===== rtl/cam_pkg.sv =====
// ----------------------------------------------------------------------------
// cam_pkg
// Shared types, widths, register indexes and the zone update function of the
// climate alarm monitor.
// ----------------------------------------------------------------------------
package cam_pkg;

    // Field widths
    localparam int TEMP_W  = 12;
    localparam int HUM_W   = 10;
    localparam int HEAT_W  = 13;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 3;

    // Common compare width: holds every temperature, humidity and heat value
    localparam int CMP_W   = 13;

    // Reset value of the peak temperature
    localparam logic signed [TEMP_W-1:0] PEAK_RESET = -12'sd1000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_LOW  = 3'd0,
        REG_TEMP_WARN = 3'd1,
        REG_TEMP_HIGH = 3'd2,
        REG_HEAT      = 3'd3,
        REG_HUM_LOW   = 3'd4,
        REG_HUM_WARN  = 3'd5,
        REG_HUM_HIGH  = 3'd6,
        REG_ENABLES   = 3'd7
    } cfg_reg_t;

    // Alarm enable bits
    localparam int EN_TEMP = 0;
    localparam int EN_HUM  = 1;

    // Zone coding
    typedef enum logic [1:0] {
        ZONE_NORMAL = 2'd0,
        ZONE_LOW    = 2'd1,
        ZONE_WARN   = 2'd2,
        ZONE_HIGH   = 2'd3
    } zone_t;

    // Held zone update: later matching checks win, ties hold the zone
    function automatic zone_t next_zone(
        input zone_t                   cur,
        input logic signed [CMP_W-1:0] v,
        input logic signed [CMP_W-1:0] lo,
        input logic signed [CMP_W-1:0] wa,
        input logic signed [CMP_W-1:0] hi
    );
        zone_t z;
        z = cur;
        if (lo != '0 && v < lo)
            z = ZONE_LOW;
        if (v > lo && v < wa)
            z = ZONE_NORMAL;
        if (wa != '0 && v > wa && v < hi)
            z = ZONE_WARN;
        if (hi != '0 && v > hi)
            z = ZONE_HIGH;
        return z;
    endfunction

endpackage

// ===== rtl/cam_if.sv =====
// ----------------------------------------------------------------------------
// cam_if
// Valid/ready channels of the climate alarm monitor: sensor readings in,
// alarm status out.
// ----------------------------------------------------------------------------
interface cam_reading_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 reading_valid;
    logic signed [cam_pkg::TEMP_W-1:0]    temp_in;
    logic        [cam_pkg::HUM_W-1:0]     hum_in;
    logic signed [cam_pkg::HEAT_W-1:0]    heat_in;

    modport source (output valid, reading_valid, temp_in, hum_in, heat_in,
                    input ready);
    modport sink   (input valid, reading_valid, temp_in, hum_in, heat_in,
                    output ready);
endinterface

interface cam_status_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 read_ok;
    logic                                 sensor_error;
    logic                                 changed;
    logic        [1:0]                    temp_zone;
    logic        [1:0]                    hum_zone;
    logic                                 heat_alarm;
    logic signed [cam_pkg::TEMP_W-1:0]    peak_temp;

    modport source (output valid, read_ok, sensor_error, changed, temp_zone,
                    hum_zone, heat_alarm, peak_temp, input ready);
    modport sink   (input valid, read_ok, sensor_error, changed, temp_zone,
                    hum_zone, heat_alarm, peak_temp, output ready);
endinterface

// ===== rtl/climate_alarm_monitor.sv =====
// ----------------------------------------------------------------------------
// climate_alarm_monitor
// Tracks sensor read attempts: error and display refresh flags, peak
// temperature, held temperature and humidity zones and the heat index alarm.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake    | beat contents
//  ----------+-----+--------------+------------------------------------------
//  reading   | in  | valid/ready  | reading_valid, temp_in, hum_in, heat_in
//  status    | out | valid/ready  | read_ok, sensor_error, changed, zones,
//            |     |              | heat_alarm, peak_temp
//  cfg       | in  | cfg_wr_en    | cfg_index, cfg_data
//
//  One reading per cycle; the status beat appears in the cycle after acceptance.
//  The rate is set by the single status register, which reloads in the same
//  cycle it is drained. rst_n clears all flags, zones, stored values, limits
//  and enables; peak temperature resets to -100.0. While status is stalled
//  the block accepts no reading and the status beat holds.
// ----------------------------------------------------------------------------
module climate_alarm_monitor (
    input  logic                              clk,
    input  logic                              rst_n,
    cam_reading_if.sink                       reading,
    cam_status_if.source                      status,
    input  logic                              cfg_wr_en,
    input  logic [cam_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cam_pkg::CFG_W-1:0]         cfg_data
);
    import cam_pkg::*;

    // Configuration registers
    logic signed [TEMP_W-1:0] temp_low_reg, temp_warn_reg, temp_high_reg;
    logic signed [HEAT_W-1:0] heat_limit_reg;
    logic        [HUM_W-1:0]  hum_low_reg, hum_warn_reg, hum_high_reg;
    logic        [1:0]        enables_reg;

    // Monitor state
    logic signed [TEMP_W-1:0] prev_temp_reg, prev_temp_next;
    logic        [HUM_W-1:0]  prev_hum_reg, prev_hum_next;
    logic signed [HEAT_W-1:0] prev_heat_reg, prev_heat_next;
    logic signed [TEMP_W-1:0] max_temp_reg, max_temp_next;
    logic                     error_reg, error_next;
    logic                     change_reg, change_next;
    zone_t                    temp_state_reg, temp_state_next;
    zone_t                    hum_state_reg, hum_state_next;
    logic                     heat_flag_reg, heat_flag_next;

    // Status output register
    logic                     out_valid_reg;
    logic                     read_ok_reg;

    logic                     accept;
    logic signed [CMP_W-1:0]  temp_x, hum_x;

    // Take a reading whenever the status slot is free or being drained
    assign reading.ready = !out_valid_reg || status.ready;
    assign accept        = reading.valid && reading.ready;

    assign temp_x = CMP_W'(reading.temp_in);
    assign hum_x  = signed'({{(CMP_W-HUM_W){1'b0}}, reading.hum_in});

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_low_reg   <= '0;
            temp_warn_reg  <= '0;
            temp_high_reg  <= '0;
            heat_limit_reg <= '0;
            hum_low_reg    <= '0;
            hum_warn_reg   <= '0;
            hum_high_reg   <= '0;
            enables_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TEMP_LOW:  temp_low_reg   <= cfg_data[TEMP_W-1:0];
                REG_TEMP_WARN: temp_warn_reg  <= cfg_data[TEMP_W-1:0];
                REG_TEMP_HIGH: temp_high_reg  <= cfg_data[TEMP_W-1:0];
                REG_HEAT:      heat_limit_reg <= cfg_data[HEAT_W-1:0];
                REG_HUM_LOW:   hum_low_reg    <= cfg_data[HUM_W-1:0];
                REG_HUM_WARN:  hum_warn_reg   <= cfg_data[HUM_W-1:0];
                REG_HUM_HIGH:  hum_high_reg   <= cfg_data[HUM_W-1:0];
                REG_ENABLES:   enables_reg    <= cfg_data[1:0];
                default:       enables_reg    <= enables_reg;
            endcase
        end
    end

    // Compute the state after this reading
    always_comb
    begin
        prev_temp_next  = prev_temp_reg;
        prev_hum_next   = prev_hum_reg;
        prev_heat_next  = prev_heat_reg;
        max_temp_next   = max_temp_reg;
        error_next      = error_reg;
        change_next     = change_reg;
        temp_state_next = temp_state_reg;
        hum_state_next  = hum_state_reg;
        heat_flag_next  = heat_flag_reg;

        if (!reading.reading_valid)
        begin
            // First failure flags a refresh, a repeated one drops it
            if (!error_reg)
            begin
                change_next = 1'b1;
                error_next  = 1'b1;
            end
            else
            begin
                change_next = 1'b0;
            end
        end
        else
        begin
            error_next = 1'b0;
            if (reading.temp_in > max_temp_reg)
                max_temp_next = reading.temp_in;
            change_next = (reading.hum_in != prev_hum_reg)
                       || (reading.temp_in != prev_temp_reg)
                       || (reading.heat_in != prev_heat_reg);
            prev_temp_next = reading.temp_in;
            prev_hum_next  = reading.hum_in;
            prev_heat_next = reading.heat_in;

            if (enables_reg[EN_TEMP])
            begin
                temp_state_next = next_zone(temp_state_reg, temp_x,
                                            CMP_W'(temp_low_reg),
                                            CMP_W'(temp_warn_reg),
                                            CMP_W'(temp_high_reg));
                heat_flag_next  = reading.heat_in > heat_limit_reg;
            end
            else
            begin
                temp_state_next = ZONE_NORMAL;
            end

            if (enables_reg[EN_HUM])
            begin
                hum_state_next = next_zone(hum_state_reg, hum_x,
                    signed'({{(CMP_W-HUM_W){1'b0}}, hum_low_reg}),
                    signed'({{(CMP_W-HUM_W){1'b0}}, hum_warn_reg}),
                    signed'({{(CMP_W-HUM_W){1'b0}}, hum_high_reg}));
            end
            else
            begin
                hum_state_next = ZONE_NORMAL;
            end
        end
    end

    // Advance state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_temp_reg  <= '0;
            prev_hum_reg   <= '0;
            prev_heat_reg  <= '0;
            max_temp_reg   <= PEAK_RESET;
            error_reg      <= 1'b0;
            change_reg     <= 1'b0;
            temp_state_reg <= ZONE_NORMAL;
            hum_state_reg  <= ZONE_NORMAL;
            heat_flag_reg  <= 1'b0;
        end
        else if (accept)
        begin
            prev_temp_reg  <= prev_temp_next;
            prev_hum_reg   <= prev_hum_next;
            prev_heat_reg  <= prev_heat_next;
            max_temp_reg   <= max_temp_next;
            error_reg      <= error_next;
            change_reg     <= change_next;
            temp_state_reg <= temp_state_next;
            hum_state_reg  <= hum_state_next;
            heat_flag_reg  <= heat_flag_next;
        end
    end

    // Hold the status beat until taken, reload on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            read_ok_reg   <= 1'b0;
        end
        else if (reading.ready)
        begin
            out_valid_reg <= reading.valid;
            if (reading.valid)
                read_ok_reg <= reading.reading_valid;
        end
    end

    // The status fields mirror the state registers after the last beat
    assign status.valid        = out_valid_reg;
    assign status.read_ok      = read_ok_reg;
    assign status.sensor_error = error_reg;
    assign status.changed      = change_reg;
    assign status.temp_zone    = temp_state_reg;
    assign status.hum_zone     = hum_state_reg;
    assign status.heat_alarm   = heat_flag_reg;
    assign status.peak_temp    = max_temp_reg;

endmodule

// ===== rtl/cam_checker.sv =====
// ----------------------------------------------------------------------------
// cam_checker
// Port-level checks of the climate alarm monitor, bound to the top level.
// ----------------------------------------------------------------------------
module cam_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              read_ok,
    input  logic                              sensor_error,
    input  logic [1:0]                        temp_zone,
    input  logic [cam_pkg::TEMP_W-1:0]        peak_temp
);
    import cam_pkg::*;

    // An accepted reading produces a status beat in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
    else $error("accepted reading produced no status beat");

    // A failed read always reports the error flag, a good one clears it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (read_ok != sensor_error))
    else $error("read_ok and sensor_error disagree");

    // A stalled status beat keeps valid high
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
    else $error("status beat dropped while stalled");

    // A stalled status beat keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            ($stable(read_ok) && $stable(temp_zone) && $stable(peak_temp)))
    else $error("status beat changed while stalled");

endmodule

bind climate_alarm_monitor cam_checker u_cam_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (reading.valid),
    .in_ready     (reading.ready),
    .out_valid    (status.valid),
    .out_ready    (status.ready),
    .read_ok      (status.read_ok),
    .sensor_error (status.sensor_error),
    .temp_zone    (status.temp_zone),
    .peak_temp    (status.peak_temp)
);

// ===== dv/tb_climate_alarm_monitor.sv =====
// ----------------------------------------------------------------------------
// tb_climate_alarm_monitor
// Self-checking testbench of the climate alarm monitor. A short table of
// directed readings and register writes runs first, then eight random phases
// under different limit settings and idle patterns. Every status beat is
// compared field by field with an in-order prediction of the alarm state.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_climate_alarm_monitor;

    import cam_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 200;
    localparam int NUM_PHASES   = 8;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic                      read_ok;
        logic                      sensor_error;
        logic                      changed;
        zone_t                     temp_zone;
        zone_t                     hum_zone;
        logic                      heat_alarm;
        logic signed [TEMP_W-1:0]  peak_temp;
    } status_t;

    typedef struct packed {
        logic                      ok;
        logic signed [TEMP_W-1:0]  temp;
        logic        [HUM_W-1:0]   hum;
        logic signed [HEAT_W-1:0]  heat;
    } reading_t;

    typedef struct {
        bit                        is_cfg;
        cfg_reg_t                  idx;
        logic [CFG_W-1:0]          data;
        reading_t                  rdg;
        bit                        lit;
        status_t                   exp;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    cam_reading_if rd ();
    cam_status_if  st ();

    climate_alarm_monitor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .reading   (rd),
        .status    (st),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the alarm state and the limit registers
    logic [CFG_W-1:0]          cfg_shadow [8];
    logic signed [TEMP_W-1:0]  last_temp  = '0;
    logic        [HUM_W-1:0]   last_hum   = '0;
    logic signed [HEAT_W-1:0]  last_heat  = '0;
    logic signed [TEMP_W-1:0]  peak_seen  = PEAK_RESET;
    logic                      err_flag   = 1'b0;
    logic                      chg_flag   = 1'b0;
    zone_t                     temp_held  = ZONE_NORMAL;
    zone_t                     hum_held   = ZONE_NORMAL;
    logic                      heat_held  = 1'b0;

    status_t   expected_status [$];
    stim_row_t directed_rows [$];
    int        mismatch_cnt = 0;
    int        cycle_cnt    = 0;
    int        src_idle_pct = 0;
    int        snk_idle_pct = 0;
    bit        cur_lit      = 1'b0;
    status_t   cur_lit_exp  = '0;

    // Clock
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Held zone after one reading: later matching checks win, ties hold
    function automatic zone_t zone_after(input zone_t cur, input int v, input int lo,
                                         input int wa, input int hi);
        zone_t z;
        z = cur;
        if (lo != 0 && v < lo)
            z = ZONE_LOW;
        if (v > lo && v < wa)
            z = ZONE_NORMAL;
        if (wa != 0 && v > wa && v < hi)
            z = ZONE_WARN;
        if (hi != 0 && v > hi)
            z = ZONE_HIGH;
        return z;
    endfunction

    // Advance the shadow alarm state by one accepted reading
    function automatic status_t advance_monitor(input reading_t r);
        status_t s;
        logic [1:0] en;
        en = cfg_shadow[REG_ENABLES][1:0];
        if (!r.ok) begin
            if (!err_flag) begin
                chg_flag = 1'b1;
                err_flag = 1'b1;
            end
            else begin
                chg_flag = 1'b0;
            end
        end
        else begin
            err_flag = 1'b0;
            if (r.temp > peak_seen)
                peak_seen = r.temp;
            chg_flag = (r.hum != last_hum) || (r.temp != last_temp) || (r.heat != last_heat);
            last_temp = r.temp;
            last_hum  = r.hum;
            last_heat = r.heat;
            if (en[EN_TEMP]) begin
                temp_held = zone_after(temp_held, int'(r.temp),
                                       int'($signed(cfg_shadow[REG_TEMP_LOW][TEMP_W-1:0])),
                                       int'($signed(cfg_shadow[REG_TEMP_WARN][TEMP_W-1:0])),
                                       int'($signed(cfg_shadow[REG_TEMP_HIGH][TEMP_W-1:0])));
                heat_held = r.heat > $signed(cfg_shadow[REG_HEAT][HEAT_W-1:0]);
            end
            else begin
                temp_held = ZONE_NORMAL;
            end
            if (en[EN_HUM]) begin
                hum_held = zone_after(hum_held, int'(r.hum),
                                      int'(cfg_shadow[REG_HUM_LOW][HUM_W-1:0]),
                                      int'(cfg_shadow[REG_HUM_WARN][HUM_W-1:0]),
                                      int'(cfg_shadow[REG_HUM_HIGH][HUM_W-1:0]));
            end
            else begin
                hum_held = ZONE_NORMAL;
            end
        end
        s.read_ok      = r.ok;
        s.sensor_error = err_flag;
        s.changed      = chg_flag;
        s.temp_zone    = temp_held;
        s.hum_zone     = hum_held;
        s.heat_alarm   = heat_held;
        s.peak_temp    = peak_seen;
        return s;
    endfunction

    // Value near one of three limits, between the given bounds, or raw bits
    function automatic int pick_near(input int l0, input int l1, input int l2,
                                     input int lo_bound, input int hi_bound);
        int k;
        int lims [3];
        lims[0] = l0;
        lims[1] = l1;
        lims[2] = l2;
        k = $urandom_range(0, 9);
        if (k < 4)
            return lims[$urandom_range(0, 2)] + $urandom_range(0, 2) - 1;
        else if (k < 9)
            return lo_bound + $urandom_range(0, hi_bound - lo_bound);
        else
            return $urandom;
    endfunction

    // Three random limits in ascending order
    task automatic pick_ordered(input int lo_bound, input int hi_bound,
                                output int a, output int b, output int c);
        int x;
        a = lo_bound + $urandom_range(0, hi_bound - lo_bound);
        b = lo_bound + $urandom_range(0, hi_bound - lo_bound);
        c = lo_bound + $urandom_range(0, hi_bound - lo_bound);
        if (a > b) begin x = a; a = b; b = x; end
        if (b > c) begin x = b; b = c; c = x; end
        if (a > b) begin x = a; a = b; b = x; end
    endtask

    // Table building
    task automatic add_read(input logic ok, input int t, input int h, input int hx);
        stim_row_t row;
        row = '{is_cfg: 1'b0, idx: REG_TEMP_LOW, data: '0, rdg: '0, lit: 1'b0, exp: '0};
        row.rdg = '{ok, TEMP_W'(t), HUM_W'(h), HEAT_W'(hx)};
        directed_rows.push_back(row);
    endtask

    task automatic add_read_lit(input logic ok, input int t, input int h, input int hx,
                                input status_t e);
        stim_row_t row;
        row = '{is_cfg: 1'b0, idx: REG_TEMP_LOW, data: '0, rdg: '0, lit: 1'b0, exp: '0};
        row.rdg = '{ok, TEMP_W'(t), HUM_W'(h), HEAT_W'(hx)};
        row.lit = 1'b1;
        row.exp = e;
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input cfg_reg_t idx, input int value);
        stim_row_t row;
        row = '{is_cfg: 1'b0, idx: REG_TEMP_LOW, data: '0, rdg: '0, lit: 1'b0, exp: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = CFG_W'(value);
        directed_rows.push_back(row);
    endtask

    // Hold until every status beat has arrived, then let the pipe settle
    task automatic wait_idle();
        while (expected_status.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One register write, called at a falling edge
    task automatic program_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_shadow[idx] = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Drive one reading beat and hold it until accepted
    task automatic drive_reading(input reading_t r, input bit lit, input status_t e);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            rd.valid <= 1'b0;
            @(negedge clk);
        end
        cur_lit     = lit;
        cur_lit_exp = e;
        rd.valid         <= 1'b1;
        rd.reading_valid <= r.ok;
        rd.temp_in       <= r.temp;
        rd.hum_in        <= r.hum;
        rd.heat_in       <= r.heat;
        do
            @(posedge clk);
        while (!rd.ready);
        @(negedge clk);
    endtask

    // Load all limits for one random phase
    task automatic configure_phase(input int p);
        logic [CFG_W-1:0] vals [8];
        int a, b, c;
        pick_ordered(-1000, 2000, a, b, c);
        vals[REG_TEMP_LOW]  = CFG_W'(a);
        vals[REG_TEMP_WARN] = CFG_W'(b);
        vals[REG_TEMP_HIGH] = CFG_W'(c);
        vals[REG_HEAT]      = CFG_W'(-1000 + $urandom_range(0, 4000));
        pick_ordered(0, 1000, a, b, c);
        vals[REG_HUM_LOW]   = CFG_W'(a);
        vals[REG_HUM_WARN]  = CFG_W'(b);
        vals[REG_HUM_HIGH]  = CFG_W'(c);
        vals[REG_ENABLES]   = CFG_W'(3);
        case (p)
            1: begin
                vals[REG_TEMP_LOW]  = CFG_W'(-1000);
                vals[REG_TEMP_WARN] = CFG_W'(-1000);
                vals[REG_TEMP_HIGH] = CFG_W'(-1000);
                vals[REG_HEAT]      = CFG_W'(-1000);
                vals[REG_HUM_LOW]   = '0;
                vals[REG_HUM_WARN]  = '0;
                vals[REG_HUM_HIGH]  = '0;
            end
            2: begin
                vals[REG_TEMP_LOW]  = CFG_W'(2000);
                vals[REG_TEMP_WARN] = CFG_W'(2000);
                vals[REG_TEMP_HIGH] = CFG_W'(2000);
                vals[REG_HEAT]      = CFG_W'(3000);
                vals[REG_HUM_LOW]   = CFG_W'(1000);
                vals[REG_HUM_WARN]  = CFG_W'(1000);
                vals[REG_HUM_HIGH]  = CFG_W'(1000);
            end
            3: begin
                // All zone thresholds disabled, heat limit zero
                for (int i = 0; i < 7; i++)
                    vals[i] = '0;
            end
            4: vals[REG_ENABLES] = CFG_W'(1);
            5: vals[REG_ENABLES] = CFG_W'(2);
            6: begin
                // Raw register bits, upper bits included
                for (int i = 0; i < 8; i++)
                    vals[i] = CFG_W'($urandom);
            end
            7: vals[REG_ENABLES] = '0;
            default: ;
        endcase
        wait_idle();
        for (int i = 0; i < 8; i++)
            program_reg(cfg_reg_t'(i), vals[i]);
    endtask

    // Receiver stalls
    always @(negedge clk)
        st.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

    // Predict on every reading beat, check every status beat
    always @(posedge clk) begin
        status_t pred;
        status_t got;
        status_t want;
        if (rst_n) begin
            if (rd.valid && rd.ready) begin
                pred = advance_monitor('{rd.reading_valid, rd.temp_in, rd.hum_in, rd.heat_in});
                expected_status.push_back(cur_lit ? cur_lit_exp : pred);
            end
            if (st.valid && st.ready) begin
                got.read_ok      = st.read_ok;
                got.sensor_error = st.sensor_error;
                got.changed      = st.changed;
                got.temp_zone    = zone_t'(st.temp_zone);
                got.hum_zone     = zone_t'(st.hum_zone);
                got.heat_alarm   = st.heat_alarm;
                got.peak_temp    = st.peak_temp;
                if (expected_status.size() == 0) begin
                    $error("status beat with no reading pending");
                    mismatch_cnt++;
                end
                else begin
                    want = expected_status.pop_front();
                    if (got.read_ok !== want.read_ok) begin
                        $error("read_ok: expected %0d, got %0d", want.read_ok, got.read_ok);
                        mismatch_cnt++;
                    end
                    if (got.sensor_error !== want.sensor_error) begin
                        $error("sensor_error: expected %0d, got %0d",
                               want.sensor_error, got.sensor_error);
                        mismatch_cnt++;
                    end
                    if (got.changed !== want.changed) begin
                        $error("changed: expected %0d, got %0d", want.changed, got.changed);
                        mismatch_cnt++;
                    end
                    if (got.temp_zone !== want.temp_zone) begin
                        $error("temp_zone: expected %0d, got %0d",
                               want.temp_zone, got.temp_zone);
                        mismatch_cnt++;
                    end
                    if (got.hum_zone !== want.hum_zone) begin
                        $error("hum_zone: expected %0d, got %0d", want.hum_zone, got.hum_zone);
                        mismatch_cnt++;
                    end
                    if (got.heat_alarm !== want.heat_alarm) begin
                        $error("heat_alarm: expected %0d, got %0d",
                               want.heat_alarm, got.heat_alarm);
                        mismatch_cnt++;
                    end
                    if (got.peak_temp !== want.peak_temp) begin
                        $error("peak_temp: expected %0d, got %0d",
                               want.peak_temp, got.peak_temp);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[climate_alarm_monitor] ERROR");
            $finish;
        end
    end

    // Stimulus
    initial begin
        stim_row_t row;
        reading_t  r;
        reading_t  last_good;
        int        bad_left;
        int        k;
        int        n;

        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        rd.valid         = 1'b0;
        rd.reading_valid = 1'b0;
        rd.temp_in       = '0;
        rd.hum_in        = '0;
        rd.heat_in       = '0;
        st.ready         = 1'b0;
        for (int i = 0; i < 8; i++)
            cfg_shadow[i] = '0;

        // Directed table: reset state, failure sequence, extremes
        add_read_lit(1'b1, 0, 0, 0,
                     '{1'b1, 1'b0, 1'b0, ZONE_NORMAL, ZONE_NORMAL, 1'b0, 12'sd0});
        add_read_lit(1'b0, 0, 0, 0,
                     '{1'b0, 1'b1, 1'b1, ZONE_NORMAL, ZONE_NORMAL, 1'b0, 12'sd0});
        add_read_lit(1'b0, 123, 45, 67,
                     '{1'b0, 1'b1, 1'b0, ZONE_NORMAL, ZONE_NORMAL, 1'b0, 12'sd0});
        add_read_lit(1'b0, 0, 0, 0,
                     '{1'b0, 1'b1, 1'b0, ZONE_NORMAL, ZONE_NORMAL, 1'b0, 12'sd0});
        add_read_lit(1'b1, 2000, 1000, 3000,
                     '{1'b1, 1'b0, 1'b1, ZONE_NORMAL, ZONE_NORMAL, 1'b0, 12'sd2000});
        add_read_lit(1'b1, -1000, 0, -1000,
                     '{1'b1, 1'b0, 1'b1, ZONE_NORMAL, ZONE_NORMAL, 1'b0, 12'sd2000});
        add_read_lit(1'b1, -1000, 0, -1000,
                     '{1'b1, 1'b0, 1'b0, ZONE_NORMAL, ZONE_NORMAL, 1'b0, 12'sd2000});
        // Out-of-range values at full field width
        add_read(1'b1, -2048, 1023, -4096);
        add_read(1'b1, 2047, 0, 4095);
        // Zone walk with ties on every limit
        add_cfg(REG_TEMP_LOW, 100);
        add_cfg(REG_TEMP_WARN, 300);
        add_cfg(REG_TEMP_HIGH, 400);
        add_cfg(REG_HEAT, 500);
        add_cfg(REG_HUM_LOW, 200);
        add_cfg(REG_HUM_WARN, 600);
        add_cfg(REG_HUM_HIGH, 800);
        add_cfg(REG_ENABLES, 3);
        add_read(1'b1, 50, 100, 400);
        add_read(1'b1, 100, 200, 500);
        add_read(1'b1, 200, 400, 501);
        add_read(1'b1, 300, 600, 0);
        add_read(1'b1, 350, 700, 600);
        add_read(1'b1, 400, 800, -1000);
        add_read(1'b1, 450, 900, 3000);
        add_read(1'b1, 380, 700, 500);
        add_read(1'b0, 0, 0, 0);
        // Humidity alarms off, then temperature alarms off with heat alarm held
        add_cfg(REG_ENABLES, 1);
        add_read(1'b1, -1000, 0, -1000);
        add_cfg(REG_ENABLES, 0);
        add_read(1'b1, 2000, 1000, 3000);

        // Reset
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table
        src_idle_pct = 36;
        snk_idle_pct = 48;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                // Drop the last reading beat before touching the registers
                rd.valid <= 1'b0;
                wait_idle();
                program_reg(row.idx, row.data);
            end
            else begin
                drive_reading(row.rdg, row.lit, row.exp);
            end
        end

        // Random phases
        last_good = '{1'b1, '0, '0, '0};
        bad_left  = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 3) begin
                src_idle_pct = 36;
                snk_idle_pct = 48;
            end
            else if (p < 6) begin
                src_idle_pct = 48;
                snk_idle_pct = 36;
            end
            else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            rd.valid <= 1'b0;
            configure_phase(p);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Sender pauses until all status beats are back
                if (n == PHASE_ITEMS / 2) begin
                    rd.valid <= 1'b0;
                    wait_idle();
                end
                k = $urandom_range(0, 99);
                if (bad_left == 0 && k < 10)
                    bad_left = $urandom_range(1, 4);
                if (bad_left > 0) begin
                    bad_left--;
                    r = '{1'b0, TEMP_W'($urandom), HUM_W'($urandom), HEAT_W'($urandom)};
                end
                else if (k < 25) begin
                    r = last_good;
                end
                else begin
                    r.ok   = 1'b1;
                    r.temp = TEMP_W'(pick_near(
                        int'($signed(cfg_shadow[REG_TEMP_LOW][TEMP_W-1:0])),
                        int'($signed(cfg_shadow[REG_TEMP_WARN][TEMP_W-1:0])),
                        int'($signed(cfg_shadow[REG_TEMP_HIGH][TEMP_W-1:0])),
                        -1000, 2000));
                    r.hum  = HUM_W'(pick_near(
                        int'(cfg_shadow[REG_HUM_LOW][HUM_W-1:0]),
                        int'(cfg_shadow[REG_HUM_WARN][HUM_W-1:0]),
                        int'(cfg_shadow[REG_HUM_HIGH][HUM_W-1:0]),
                        0, 1000));
                    r.heat = HEAT_W'(pick_near(
                        int'($signed(cfg_shadow[REG_HEAT][HEAT_W-1:0])),
                        int'($signed(cfg_shadow[REG_HEAT][HEAT_W-1:0])),
                        int'($signed(cfg_shadow[REG_HEAT][HEAT_W-1:0])),
                        -1000, 3000));
                    last_good = r;
                end
                drive_reading(r, 1'b0, '0);
            end
        end
        rd.valid <= 1'b0;

        // Drain and report
        wait_idle();
        repeat (4 * DRAIN_CYCLES) @(negedge clk);
        if (mismatch_cnt == 0 && expected_status.size() == 0)
            $display("[climate_alarm_monitor] OK");
        else
            $display("[climate_alarm_monitor] ERROR");
        $finish;
    end

endmodule
